### rtl/core/fla_pkg.sv
// Shared types, constants and helper functions for the free-list allocator.
`default_nettype none
package fla_pkg;

	localparam int MAX_BLOCKS      = 255;
	localparam int MAX_BLOCK_BYTES = 256;

	localparam int LINK_AW  = $clog2(MAX_BLOCKS);
	localparam int SIZE_W   = 9;
	localparam int COUNT_W  = 8;
	localparam int OFFSET_W = 16;
	localparam int ACC_W    = OFFSET_W + 1;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = SIZE_W;
	localparam int STEP_W   = $clog2(OFFSET_W + 1);

	localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(OFFSET_W);
	localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(LINK_AW);

	// Operation codes
	localparam logic [OP_W-1:0] OP_REBUILD = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic [SIZE_W-1:0]  SIZE_RST  = 9'd8;
	localparam logic [COUNT_W-1:0] COUNT_RST = 8'd255;

	// Request to the shared shift-add unit
	typedef struct packed {
		logic start;
		logic div;
	} alu_req_t;

	// Clamp the block size register to its usable range
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (v > SIZE_W'(MAX_BLOCK_BYTES)) r = SIZE_W'(MAX_BLOCK_BYTES);
		return r;
	endfunction

	// Clamp the block count register to its usable range
	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = v;
		if (v == '0) r = COUNT_W'(1);
		else if (v > COUNT_W'(MAX_BLOCKS)) r = COUNT_W'(MAX_BLOCKS);
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/fla_shift_alu.sv
// Shared shift-add/subtract unit: serial multiply and restoring divide.
`default_nettype none
module fla_shift_alu (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire fla_pkg::alu_req_t    req,
	input  wire [fla_pkg::OFFSET_W-1:0] opnd_in,
	input  wire [fla_pkg::SIZE_W-1:0]   size,
	output logic                      done,
	output logic [fla_pkg::ACC_W-1:0]   acc,
	output logic [fla_pkg::OFFSET_W-1:0] opnd
);
	import fla_pkg::*;

	logic                run_q;
	logic                done_q;
	logic                div_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [OFFSET_W-1:0] opnd_q;

	logic [ACC_W-1:0]    shifted;
	logic [ACC_W-1:0]    addend;
	logic [ACC_W:0]      sum;
	logic                ge;

	// One step: shift the accumulator, then add (multiply) or subtract (divide)
	always_comb begin
		shifted = {acc_q[ACC_W-2:0], div_q & opnd_q[OFFSET_W-1]};
		if (div_q) addend = ~ACC_W'(size);
		else addend = opnd_q[OFFSET_W-1] ? ACC_W'(size) : '0;
		sum = {1'b0, shifted} + {1'b0, addend} + (ACC_W+1)'(div_q);
		ge  = sum[ACC_W];
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				div_q <= req.div;
				cnt_q <= req.div ? DIV_STEPS : MUL_STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Advance the datapath; quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			opnd_q <= opnd_in;
		end else if (run_q) begin
			if (div_q) begin
				acc_q  <= ge ? sum[ACC_W-1:0] : shifted;
				opnd_q <= {opnd_q[OFFSET_W-2:0], ge};
			end else begin
				acc_q  <= sum[ACC_W-1:0];
				opnd_q <= {opnd_q[OFFSET_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign opnd = opnd_q;

endmodule
`default_nettype wire

### rtl/core/fla_link_store.sv
// Next-link memory of the free list with per-entry valid bits.
`default_nettype none
module fla_link_store (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        clr,
	input  wire                        wr_en,
	input  wire [fla_pkg::LINK_AW-1:0] wr_addr,
	input  wire [fla_pkg::LINK_AW-1:0] wr_data,
	input  wire                        rd_en,
	input  wire [fla_pkg::LINK_AW-1:0] rd_addr,
	output logic [fla_pkg::LINK_AW-1:0] rd_data
);
	import fla_pkg::*;

	logic [LINK_AW-1:0]    mem [0:MAX_BLOCKS-1];
	logic [MAX_BLOCKS-1:0] valid_q;
	logic                  rd_valid_q;
	logic [LINK_AW-1:0]    rd_mem_q;
	logic [LINK_AW-1:0]    rd_addr_q;

	// Track written entries; an unwritten entry links to the next block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr) valid_q <= '0;
			else if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Write and read the array
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_mem_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	assign rd_data = rd_valid_q ? rd_mem_q : rd_addr_q + LINK_AW'(1);

endmodule
`default_nettype wire

### rtl/core/embedded_free_list_allocator.sv
// Top level: command sequencer, list head and count, config and result registers.
//
// Fixed-size block allocator over a singly linked free list of up to 255 blocks.
// An operation is taken on a clock edge with start high and busy low; its one
// result shows on the result ports for exactly one cycle with done high, and
// busy is low again in that same cycle. Rebuild, the unused opcode and any
// request rejected up front (alloc on an empty list, free with the list full)
// show their result in the cycle after the start edge. A good alloc and a free
// run through one shared shift-add unit, 8 multiply steps for the byte offset
// and 16 restoring-divide steps for the offset-to-index conversion, and show
// their result when the unit is done. Rebuild takes effect at once through valid
// bits on the link memory; no clearing pass is run.
// Write block_size and block_count only while busy is low and done is low.
`default_nettype none
module embedded_free_list_allocator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [fla_pkg::OP_W-1:0]      opcode,
	input  wire [fla_pkg::OFFSET_W-1:0]  free_offset,
	input  wire                          cfg_we,
	input  wire [fla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [fla_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                         done,
	output logic [fla_pkg::STATUS_W-1:0] status,
	output logic [fla_pkg::OFFSET_W-1:0] alloc_offset,
	output logic [fla_pkg::LINK_AW-1:0]  block_index,
	output logic [fla_pkg::COUNT_W-1:0]  free_blocks
);
	import fla_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ALLOC = 2'd1;
	localparam logic [1:0] S_FREE  = 2'd2;

	logic [1:0]          state_q;
	logic [SIZE_W-1:0]   block_size_q;
	logic [COUNT_W-1:0]  block_count_q;
	logic [LINK_AW-1:0]  head_q;
	logic [COUNT_W-1:0]  total_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [OFFSET_W-1:0] aoff_q;
	logic [LINK_AW-1:0]  idx_q;

	logic [SIZE_W-1:0]   size_eff;
	logic [COUNT_W-1:0]  count_eff;
	logic                accept;
	logic                alloc_empty;
	logic                free_full;
	alu_req_t            alu_req;
	logic [OFFSET_W-1:0] alu_opnd_in;
	logic                alu_done;
	logic [ACC_W-1:0]    alu_acc;
	logic [OFFSET_W-1:0] alu_opnd;
	logic                free_bad;
	logic                link_clr;
	logic                link_wr;
	logic                link_rd;
	logic [LINK_AW-1:0]  link_rd_data;

	assign size_eff    = eff_size(block_size_q);
	assign count_eff   = eff_count(block_count_q);
	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign alloc_empty = (total_q == '0) || (head_q >= count_eff);
	assign free_full   = (total_q >= count_eff);

	// Kick the shared unit for a multiply (alloc) or divide (free)
	always_comb begin
		alu_req.start = accept &&
			((opcode == OP_ALLOC && !alloc_empty) || (opcode == OP_FREE && !free_full));
		alu_req.div   = (opcode == OP_FREE);
		alu_opnd_in   = (opcode == OP_FREE) ? free_offset :
			{head_q, (OFFSET_W-LINK_AW)'(0)};
	end

	// Reject a free that is misaligned or past the last block
	assign free_bad = (alu_acc != '0) || (alu_opnd >= OFFSET_W'(count_eff));

	assign link_clr = accept && (opcode == OP_REBUILD);
	assign link_rd  = accept && (opcode == OP_ALLOC) && !alloc_empty;
	assign link_wr  = (state_q == S_FREE) && alu_done && !free_bad;

	fla_shift_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (alu_req),
		.opnd_in (alu_opnd_in),
		.size    (size_eff),
		.done    (alu_done),
		.acc     (alu_acc),
		.opnd    (alu_opnd)
	);

	fla_link_store u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (link_clr),
		.wr_en   (link_wr),
		.wr_addr (alu_opnd[LINK_AW-1:0]),
		.wr_data (head_q),
		.rd_en   (link_rd),
		.rd_addr (head_q),
		.rd_data (link_rd_data)
	);

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= SIZE_RST;
			block_count_q <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLOCK_SIZE:  block_size_q  <= cfg_wdata;
				REG_BLOCK_COUNT: block_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequence operations and update head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			total_q <= eff_count(COUNT_RST);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_REBUILD: begin
								head_q  <= '0;
								total_q <= count_eff;
								done_q  <= 1'b1;
							end
							OP_ALLOC: begin
								if (alloc_empty) done_q <= 1'b1;
								else state_q <= S_ALLOC;
							end
							OP_FREE: begin
								if (free_full) done_q <= 1'b1;
								else state_q <= S_FREE;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_ALLOC: begin
					if (alu_done) begin
						head_q  <= link_rd_data;
						total_q <= total_q - COUNT_W'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					if (alu_done) begin
						if (!free_bad) begin
							head_q  <= alu_opnd[LINK_AW-1:0];
							total_q <= total_q + COUNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= ST_OK;
			aoff_q   <= '0;
			idx_q    <= '0;
			if (opcode == OP_ALLOC && alloc_empty) status_q <= ST_EMPTY;
			if (opcode == OP_FREE && free_full) status_q <= ST_BAD_FREE;
		end else if (state_q == S_ALLOC && alu_done) begin
			aoff_q <= alu_acc[OFFSET_W-1:0];
			idx_q  <= head_q;
		end else if (state_q == S_FREE && alu_done) begin
			if (free_bad) status_q <= ST_BAD_FREE;
			else idx_q <= alu_opnd[LINK_AW-1:0];
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign alloc_offset = aoff_q;
	assign block_index  = idx_q;
	assign free_blocks  = total_q;

	// A result beat never shows while an operation is still running
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !done_q)
		else $error("result beat during a running operation");

	// The shared unit finishes only for an operation that started it
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_ALLOC || state_q == S_FREE))
		else $error("shared unit finished with no operation running");

	// A failed request reports no block
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (aoff_q == '0 && idx_q == '0))
		else $error("error result carries a block");

	// A successful free grows the count by one on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		link_wr |=> (total_q == $past(total_q) + COUNT_W'(1)))
		else $error("free did not push onto the list");

endmodule
`default_nettype wire
